>>> design/sust_pkg.sv
// Shared types and constants for the sorted universe sequence table.
// No dependencies; imported by the store, the controller and the top level.
`default_nettype none
package sust_pkg;

	localparam int MAX_UNIVERSES = 512;
	localparam int IDX_W = $clog2(MAX_UNIVERSES);
	localparam int CNT_W = $clog2(MAX_UNIVERSES + 1);
	localparam int UNI_W = 16;
	localparam int SEQ_W = 8;
	localparam int ENTRY_W = UNI_W + SEQ_W;
	localparam int OCNT_W = 10;
	localparam logic [31:0] GROUP_BASE = 32'hEFFF_0000;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ENTRY_W-1:0] entry_t;

	// One read and one write request to the entry store per cycle.
	typedef struct packed {
		logic re;
		idx_t raddr;
		logic we;
		idx_t waddr;
		entry_t wdata;
	} mem_req_t;

	// Result held by the controller until the output transaction completes.
	typedef struct packed {
		logic valid;
		logic [SEQ_W-1:0] seq;
		logic inserted;
		logic full;
		logic [OCNT_W-1:0] count;
		logic [UNI_W-1:0] universe;
	} res_t;

	// Entry count as seen on the port: the whole fill count, which fits the port width.
	function automatic logic [OCNT_W-1:0] out_count(input cnt_t c);
		logic [CNT_W+OCNT_W-1:0] t;
		t = {{OCNT_W{1'b0}}, c};
		return t[OCNT_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> design/sust_store.sv
// Entry store: one synchronous memory of universe/counter entries,
// one write and one registered read per cycle. Depends on sust_pkg.
`default_nettype none
module sust_store import sust_pkg::*; (
	input wire logic clk,
	input wire mem_req_t req,
	output entry_t rdata
);

	entry_t mem [MAX_UNIVERSES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/sust_ctrl.sv
// Sequencer for the table: binary search, counter update, shift-up insert,
// and the held result. Depends on sust_pkg; drives sust_store.
`default_nettype none
module sust_ctrl import sust_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [UNI_W-1:0] universe,
	input wire logic out_stall,
	input wire entry_t rdata,
	output mem_req_t req,
	output res_t res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEARCH = 3'd1;
	localparam logic [2:0] ST_COMPARE = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_INSERT = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic [2:0] state_q;
	logic [UNI_W-1:0] u_q;
	cnt_t lo_q;
	cnt_t hip1_q;	// upper search bound plus one
	cnt_t count_q;
	idx_t mid_q;
	idx_t idx_q;
	logic [SEQ_W-1:0] seq_q;
	logic ins_q;
	logic full_q;

	logic [CNT_W:0] mid_sum;
	cnt_t mid_c;
	cnt_t cnt_m1;
	logic [UNI_W-1:0] mu;
	logic [SEQ_W-1:0] seq_inc;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hip1_q} - 1'b1;
	assign mid_c = mid_sum[CNT_W:1];
	assign cnt_m1 = count_q - 1'b1;
	assign mu = rdata[ENTRY_W-1:SEQ_W];
	assign seq_inc = rdata[SEQ_W-1:0] + 1'b1;

	always_comb begin
		req = '0;
		unique case (state_q)
			ST_SEARCH: begin
				if (lo_q < hip1_q) begin
					req.re = 1'b1;
					req.raddr = mid_c[IDX_W-1:0];
				end else if (count_q != CNT_W'(MAX_UNIVERSES) && lo_q != count_q) begin
					req.re = 1'b1;
					req.raddr = cnt_m1[IDX_W-1:0];
				end
			end
			ST_COMPARE: begin
				if (mu == u_q) begin
					req.we = 1'b1;
					req.waddr = mid_q;
					req.wdata = {mu, seq_inc};
				end
			end
			ST_SHIFT: begin
				// Move the entry read last cycle up one place while fetching the next lower one.
				req.we = 1'b1;
				req.waddr = idx_q + 1'b1;
				req.wdata = rdata;
				if (idx_q != lo_q[IDX_W-1:0]) begin
					req.re = 1'b1;
					req.raddr = idx_q - 1'b1;
				end
			end
			ST_INSERT: begin
				req.we = 1'b1;
				req.waddr = lo_q[IDX_W-1:0];
				req.wdata = {u_q, {SEQ_W{1'b0}}};
			end
			ST_IDLE, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (lo_q < hip1_q) begin
						state_q <= ST_COMPARE;
					end else if (count_q == CNT_W'(MAX_UNIVERSES)) begin
						state_q <= ST_OUT;
					end else if (lo_q == count_q) begin
						state_q <= ST_INSERT;
					end else begin
						state_q <= ST_SHIFT;
					end
				end
				ST_COMPARE: begin
					if (mu == u_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SHIFT: begin
					if (idx_q == lo_q[IDX_W-1:0]) begin
						state_q <= ST_INSERT;
					end
				end
				ST_INSERT: begin
					state_q <= ST_OUT;
					count_q <= count_q + 1'b1;
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Search bounds, shift index and result fields.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				u_q <= universe;
				lo_q <= '0;
				hip1_q <= count_q;
				seq_q <= '0;
				ins_q <= 1'b0;
				full_q <= 1'b0;
			end
			ST_SEARCH: begin
				mid_q <= mid_c[IDX_W-1:0];
				idx_q <= cnt_m1[IDX_W-1:0];
				full_q <= (lo_q >= hip1_q) && (count_q == CNT_W'(MAX_UNIVERSES));
			end
			ST_COMPARE: begin
				if (mu < u_q) begin
					lo_q <= mid_c + 1'b1;
				end else if (mu > u_q) begin
					hip1_q <= mid_c;
				end else begin
					seq_q <= seq_inc;
				end
			end
			ST_SHIFT: begin
				idx_q <= idx_q - 1'b1;
			end
			ST_INSERT: begin
				ins_q <= 1'b1;
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign res.valid = (state_q == ST_OUT);
	assign res.seq = seq_q;
	assign res.inserted = ins_q;
	assign res.full = full_q;
	assign res.count = out_count(count_q);
	assign res.universe = u_q;

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		req.we |-> (CNT_W'(req.waddr) <= count_q))
		else $error("store write beyond the occupied entries");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_UNIVERSES))
		else $error("entry count above table size");

	a_full_no_insert: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.full && res.inserted))
		else $error("result flags both full and inserted");

	a_accept_starts_search: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_SEARCH))
		else $error("accepted transaction did not start a search");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSERT) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not advance the entry count");

endmodule
`default_nettype wire

>>> design/sorted_universe_sequence_table.sv
// Sorted universe sequence table. One request takes a binary search over the
// occupied entries (at most log2(MAX_UNIVERSES)+1 probes, each a read and a
// compare) and, for a new universe, moves each entry above the insert point up
// one place in the entry memory before writing the new entry. Requests are taken
// one at a time; a result is held until the output transaction completes. No
// clearing pass is needed after reset since only entries below the fill count
// are ever read.
// Depends on sust_pkg, sust_store and sust_ctrl.
`default_nettype none
module sorted_universe_sequence_table import sust_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [15:0] universe,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] sequence_value,
	output logic [31:0] multicast_address,
	output logic was_inserted,
	output logic table_full,
	output logic [9:0] entry_count
);

	mem_req_t req;
	entry_t rdata;
	res_t res;

	sust_store u_store (
		.clk(clk),
		.req(req),
		.rdata(rdata)
	);

	sust_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.universe(universe),
		.out_stall(out_stall),
		.rdata(rdata),
		.req(req),
		.res(res)
	);

	// Group 239.255.hi.lo: the universe number fills the low two octets.
	assign multicast_address = GROUP_BASE | {16'h0000, res.universe};
	assign out_valid = res.valid;
	assign sequence_value = res.seq;
	assign was_inserted = res.inserted;
	assign table_full = res.full;
	assign entry_count = res.count;

endmodule
`default_nettype wire

>>> tb/sust_sequence_check.sv
// Checker for the sorted universe sequence table: watches both channels, predicts each
// result from its own copy of the table, and compares. Depends on sust_pkg.
module sust_sequence_check import sust_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [15:0] universe,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] sequence_value,
	input logic [31:0] multicast_address,
	input logic was_inserted,
	input logic table_full,
	input logic [9:0] entry_count,
	output int mismatches,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] seq;
		logic [31:0] group;
		logic inserted;
		logic full;
		logic [9:0] count;
	} lookup_result_t;

	// The search order inside the block does not change any result, so the table is
	// kept here as a presence flag and a counter per universe plus the fill count.
	bit present [0:65535];
	logic [7:0] seq_of [0:65535];
	int stored;
	lookup_result_t owed_results [$];

	function automatic lookup_result_t lookup_universe(input logic [15:0] u);
		lookup_result_t r;
		r.seq = '0;
		r.group = GROUP_BASE | {16'h0000, u};
		r.inserted = 1'b0;
		r.full = 1'b0;
		if (present[u]) begin
			seq_of[u] = seq_of[u] + 8'd1;
			r.seq = seq_of[u];
		end else if (stored >= MAX_UNIVERSES) begin
			r.full = 1'b1;
		end else begin
			present[u] = 1'b1;
			seq_of[u] = '0;
			stored++;
			r.inserted = 1'b1;
		end
		r.count = stored[9:0];
		return r;
	endfunction

	task automatic note_mismatch(input string why, input lookup_result_t want,
			input lookup_result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s: expected seq=%0d group=%h ins=%b full=%b count=%0d",
				$realtime, why, want.seq, want.group, want.inserted, want.full, want.count);
			$display("%0t: %s:      got seq=%0d group=%h ins=%b full=%b count=%0d",
				$realtime, why, got.seq, got.group, got.inserted, got.full, got.count);
		end
	endtask

	initial begin
		mismatches = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		lookup_result_t got;
		lookup_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < 65536; i++) begin
				present[i] = 1'b0;
				seq_of[i] = '0;
			end
			stored = 0;
			owed_results.delete();
			pending = 0;
		end else begin
			got.seq = sequence_value;
			got.group = multicast_address;
			got.inserted = was_inserted;
			got.full = table_full;
			got.count = entry_count;
			// Results are taken before requests so that a result can never be matched
			// against a request accepted in the same cycle.
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					note_mismatch("unexpected transaction", '0, got);
				end else begin
					want = owed_results.pop_front();
					if (got.seq !== want.seq || got.group !== want.group
							|| got.inserted !== want.inserted || got.full !== want.full
							|| got.count !== want.count) begin
						note_mismatch("wrong result", want, got);
					end
				end
			end
			if (in_valid && !in_stall) begin
				owed_results.push_back(lookup_universe(universe));
			end
			pending = owed_results.size();
		end
	end

endmodule

>>> tb/testbench.sv
// Top of the testbench for the sorted universe sequence table: clock, reset, requests,
// receiver stalls, watchdog and verdict. Depends on sust_pkg, the block and the checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sust_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 600;
	localparam logic [15:0] HOT_UNIVERSE = 16'h04D2;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [15:0] universe;
	logic out_valid;
	logic out_stall;
	logic [7:0] sequence_value;
	logic [31:0] multicast_address;
	logic was_inserted;
	logic table_full;
	logic [9:0] entry_count;
	int mismatches;
	int pending;

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int quiet = 0;
	bit seen [0:65535];
	logic [15:0] seen_list [$];
	logic [15:0] corner_universes [0:14] = '{
		16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000,
		16'h0001, 16'hFFFE, 16'h00FF, 16'hFF00, 16'h5555,
		16'hAAAA, 16'h0000, 16'h8000, 16'h7FFF, 16'h8001
	};

	sorted_universe_sequence_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.universe(universe),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sequence_value(sequence_value),
		.multicast_address(multicast_address),
		.was_inserted(was_inserted),
		.table_full(table_full),
		.entry_count(entry_count)
	);

	sust_sequence_check table_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.universe(universe),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sequence_value(sequence_value),
		.multicast_address(multicast_address),
		.was_inserted(was_inserted),
		.table_full(table_full),
		.entry_count(entry_count),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offers one request and returns at the edge where the transaction completes.
	task automatic push_universe(input logic [15:0] u);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		universe <= u;
		if (!seen[u]) begin
			seen[u] = 1'b1;
			seen_list.push_back(u);
		end
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic [15:0] fresh_universe();
		logic [15:0] u;
		do begin
			u = 16'($urandom_range(65535));
		end while (seen[u]);
		return u;
	endfunction

	function automatic logic [15:0] known_universe();
		return seen_list[$urandom_range(seen_list.size() - 1)];
	endfunction

	// The receiver is the only driver of out_stall; a requested hold-off keeps it high
	// for a long stretch so that the held result backs up into the request channel.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
			end
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		universe = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Empty table, extreme universes, inserts at both ends and in the middle.
		foreach (corner_universes[i]) push_universe(corner_universes[i]);

		// Repeated hits on one universe between a few random ones.
		send_idle_pct = 50;
		for (int i = 0; i < 24; i++) begin
			push_universe((i % 8 == 7) ? 16'($urandom) : HOT_UNIVERSE);
		end

		send_idle_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++) push_universe(fresh_universe());

		// Fill the table with new universes, with occasional hits, rotating idle patterns.
		n = 0;
		while (seen_list.size() < MAX_UNIVERSES) begin
			case ((n / 128) % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 50;
				end
				1: begin
					send_idle_pct = 20;
					stall_pct = 20;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				default: begin
					send_idle_pct = 50;
					stall_pct = 0;
				end
			endcase
			push_universe(($urandom_range(19) == 0) ? known_universe() : fresh_universe());
			n++;
		end

		// Full table: new universes are refused, known ones still count up.
		send_idle_pct = 20;
		stall_pct = 20;
		for (int i = 0; i < 16; i++) begin
			push_universe($urandom_range(1) ? fresh_universe() : known_universe());
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/sust_pkg.sv
design/sust_store.sv
design/sust_ctrl.sv
design/sorted_universe_sequence_table.sv
tb/sust_sequence_check.sv
tb/testbench.sv
